### src/lssg_pkg.sv
package lssg_pkg;

    localparam int MAX_PIXELS_DEF = 64;
    localparam int POS_FRAC_DEF   = 16;

    // configuration register indexes
    localparam logic REG_STRIP_LENGTH = 1'b0;
    localparam logic REG_GLIDE_SPEED  = 1'b1;

    localparam logic [6:0] STRIP_LENGTH_RST = 7'd64;
    localparam logic [7:0] GLIDE_SPEED_RST  = 8'd40;

    localparam logic [31:0] SEED_MUL = 32'd2654435761;
    localparam logic [31:0] SEED_ADD = 32'd12345;
    localparam logic [31:0] LCG_MUL  = 32'd1664525;
    localparam logic [31:0] LCG_ADD  = 32'd1013904223;

    localparam logic [7:0] PAUSE_MIN  = 8'd40;
    localparam logic [7:0] PAUSE_SPAN = 8'd180;

    localparam logic [10:0] TAIL_DIV  = 11'd25;
    localparam logic [10:0] SPEED_DIV = 11'd1275;
    localparam logic [7:0]  GAUSS_DIV = 8'd162;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // 2^(-j/16) in Q16, j = 0..16
    function automatic logic [16:0] pow2_frac(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

### src/lssg_div.sv
module lssg_div
    import lssg_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // one quotient bit per cycle, restoring
    assign trial = {r_reg, q_reg[NW-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                q_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                r_reg   <= ge ? diff[DW-1:0] : trial[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

### src/lssg_fifo.sv
module lssg_fifo
    import lssg_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   cnt_reg;
    logic         do_push;
    logic         do_pop;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### src/lssg_front.sv
module lssg_front
    import lssg_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF,
    parameter int FRAC       = POS_FRAC_DEF,
    parameter int DESC_W     = 2 * FRAC + 21
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,
    input  logic              s_tuser,
    output logic              q_push,
    output logic [DESC_W-1:0] q_data,
    input  logic              q_full
);

    localparam int PW = FRAC + 9;
    localparam int TW = FRAC + 4;
    localparam int LEN_RST = (MAX_PIXELS < 64) ? MAX_PIXELS : 64;

    // reciprocal constants: exact floor division over the full numerator range
    localparam int TNW = FRAC + 9;
    localparam int TK  = TNW + 5;
    localparam int TPW = 2 * TNW + 1;
    localparam longint TM =
        ((longint'(1) << TK) + longint'(TAIL_DIV) - 1) / longint'(TAIL_DIV);
    localparam int SNW = FRAC + 8;
    localparam int SK  = SNW + 11;
    localparam int SPW = 2 * SNW + 1;
    localparam longint SM =
        ((longint'(1) << SK) + longint'(SPEED_DIV) - 1) / longint'(SPEED_DIV);
    localparam int LK = 40;
    localparam longint LM =
        ((longint'(1) << LK) + longint'(PAUSE_SPAN) - 1) / longint'(PAUSE_SPAN);

    localparam longint ONE_L = longint'(1) << FRAC;
    localparam logic signed [PW-1:0] ONE   = PW'(ONE_L);
    localparam logic signed [PW-1:0] STEP0 = PW'(ONE_L / 125);
    localparam logic signed [PW-1:0] END_C = PW'((19 * ONE_L) / 5);
    localparam logic signed [PW-1:0] POS_RST =
        PW'(-(((LEN_RST * 4 * ONE_L) / 25) + 3 * ONE_L));

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_TAIL = 3'd1;
    localparam logic [2:0] F_STEP = 3'd2;
    localparam logic [2:0] F_PUSH = 3'd3;
    localparam logic [2:0] F_LCG  = 3'd4;
    localparam logic [2:0] F_MOD  = 3'd5;
    localparam logic [2:0] F_REM  = 3'd6;

    logic [2:0]           state_reg;
    logic [6:0]           len_reg;
    logic [7:0]           speed_reg;
    logic signed [PW-1:0] pos_reg;
    logic [31:0]          rng_reg;
    logic [7:0]           left_reg;
    logic                 paused_reg;
    logic                 restart_reg;
    logic [TW-1:0]        tail_reg;
    logic signed [PW-1:0] step_reg;
    logic [31:0]          lq_reg;

    logic [6:0]           len_eff;
    logic signed [PW-1:0] start_pos;
    logic signed [PW-1:0] pos_cur;
    logic signed [PW-1:0] pos_next;
    logic signed [PW-1:0] end_pos;
    logic [31:0]          rng_next;
    logic [31:0]          seed_next;
    logic                 accept;

    logic [TNW-1:0]       tail_num;
    logic [TPW-1:0]       tail_prod;
    logic [SNW-1:0]       speed_num;
    logic [SPW-1:0]       speed_prod;
    logic [64:0]          lcg_prod;
    logic [31:0]          rem_full;

    assign s_tready = state_reg == F_IDLE;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (len_reg == 7'd0) begin
            len_eff = 7'd1;
        end else if (len_reg > 7'(MAX_PIXELS)) begin
            len_eff = 7'(MAX_PIXELS);
        end else begin
            len_eff = len_reg;
        end
    end

    assign start_pos = -(signed'(PW'(tail_reg)) + ONE + ONE);
    assign pos_cur   = restart_reg ? start_pos : pos_reg;
    assign pos_next  = pos_cur + step_reg;
    assign end_pos   = signed'(PW'(len_eff) << FRAC) + END_C;
    assign rng_next  = rng_reg * LCG_MUL + LCG_ADD;
    assign seed_next = s_tdata * SEED_MUL + SEED_ADD;

    assign tail_num   = TNW'(len_eff) << (FRAC + 2);
    assign tail_prod  = TPW'(tail_num) * TPW'(TM);
    assign speed_num  = SNW'(speed_reg) << FRAC;
    assign speed_prod = SPW'(speed_num) * SPW'(SM);
    assign lcg_prod   = 65'(rng_reg) * 65'(LM);
    assign rem_full   = rng_reg - lq_reg * 32'(PAUSE_SPAN);

    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign q_data = {len_eff, !paused_reg, tail_reg, pos_cur};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            len_reg     <= STRIP_LENGTH_RST;
            speed_reg   <= GLIDE_SPEED_RST;
            pos_reg     <= POS_RST;
            rng_reg     <= '0;
            left_reg    <= '0;
            paused_reg  <= 1'b0;
            restart_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_STRIP_LENGTH: len_reg   <= cfg_wdata[6:0];
                    REG_GLIDE_SPEED:  speed_reg <= cfg_wdata;
                    default:          len_reg   <= len_reg;
                endcase
            end
            case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        restart_reg <= s_tuser;
                        if (s_tuser) begin
                            rng_reg    <= seed_next;
                            left_reg   <= '0;
                            paused_reg <= 1'b0;
                        end
                        state_reg <= F_TAIL;
                    end
                end
                F_TAIL: begin
                    tail_reg  <= TW'(tail_prod >> TK) + TW'(ONE_L);
                    state_reg <= F_STEP;
                end
                F_STEP: begin
                    step_reg  <= STEP0 + signed'(PW'(speed_prod >> SK));
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (!q_full) begin
                        if (!paused_reg) begin
                            pos_reg <= pos_next;
                            if (pos_next > end_pos) begin
                                paused_reg <= 1'b1;
                                state_reg  <= F_LCG;
                            end else begin
                                state_reg <= F_IDLE;
                            end
                        end else begin
                            // the frame that finds the count at zero is still dark
                            if (left_reg == 8'd0) begin
                                paused_reg <= 1'b0;
                                pos_reg    <= start_pos;
                            end else begin
                                left_reg <= left_reg - 8'd1;
                            end
                            state_reg <= F_IDLE;
                        end
                    end
                end
                F_LCG: begin
                    rng_reg   <= rng_next;
                    state_reg <= F_MOD;
                end
                F_MOD: begin
                    lq_reg    <= 32'(lcg_prod >> LK);
                    state_reg <= F_REM;
                end
                F_REM: begin
                    left_reg  <= PAUSE_MIN + rem_full[7:0];
                    state_reg <= F_IDLE;
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

### src/lssg_back.sv
module lssg_back
    import lssg_pkg::*;
#(
    parameter int FRAC   = POS_FRAC_DEF,
    parameter int DESC_W = 2 * FRAC + 21
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  logic [DESC_W-1:0] q_data,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tlast
);

    localparam int PW   = FRAC + 9;
    localparam int TW   = FRAC + 4;
    localparam int NB   = PW + 15;
    localparam int D16W = PW + 8;
    localparam int SH_R = (FRAC >= 16) ? FRAC - 16 : 0;
    localparam int SH_L = (FRAC >= 16) ? 0 : 16 - FRAC;

    // floor(m / 162) as a reciprocal multiply, exact for any 29-bit m
    localparam int GK = 37;
    localparam longint GM =
        ((longint'(1) << GK) + longint'(GAUSS_DIV) - 1) / longint'(GAUSS_DIV);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_PIX  = 4'd1;
    localparam logic [3:0] B_SQ   = 4'd2;
    localparam logic [3:0] B_DIV  = 4'd3;
    localparam logic [3:0] B_Y    = 4'd4;
    localparam logic [3:0] B_LUT  = 4'd5;
    localparam logic [3:0] B_G    = 4'd6;
    localparam logic [3:0] B_OUT  = 4'd7;
    localparam logic [3:0] B_GQ   = 4'd8;

    logic [3:0]           state_reg;
    logic [6:0]           len_reg;
    logic                 draw_reg;
    logic [TW-1:0]        tail_reg;
    logic signed [PW-1:0] pos_reg;
    logic [5:0]           pix_reg;
    logic [39:0]          sq_reg;
    logic [28:0]          m_reg;
    logic [19:0]          xs_reg;
    logic [20:0]          y_reg;
    logic [16:0]          a_reg;
    logic [26:0]          prod_reg;
    logic [3:0]           k_reg;
    logic [16:0]          g_reg;

    logic        out_valid_reg;
    logic [5:0]  out_pix_reg;
    logic [7:0]  out_bri_reg;
    logic        out_last_reg;

    logic signed [PW-1:0] d;
    logic [PW-1:0]        nd;
    logic [D16W-1:0]      d16w;
    logic [19:0]          d16s;
    logic [44:0]          sq25;
    logic [58:0]          gq_prod;
    logic [36:0]          y_full;
    logic [4:0]           lut_idx;
    logic [16:0]          lut_a;
    logic [16:0]          lut_b;
    logic [16:0]          v;
    logic [24:0]          g255;
    logic [24:0]          g250;
    logic [7:0]           bri;
    logic                 last_pix;
    logic                 out_free;

    logic          div_start;
    logic [NB-1:0] div_num;
    logic [TW-1:0] div_den;
    logic          div_busy;
    logic          div_done;
    logic [NB-1:0] div_quot;
    logic [TW-1:0] div_rem;

    lssg_div #(.NW(NB), .DW(TW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    assign d    = signed'(PW'(pix_reg) << FRAC) - pos_reg;
    assign nd   = PW'(-d);
    assign d16w = (D16W'(d) >> SH_R) << SH_L;
    // anything this far ahead ends up dark anyway: saturate
    assign d16s = (d16w[D16W-1:20] != '0) ? 20'hFFFFF : d16w[19:0];
    assign sq25 = 45'(sq_reg) * 45'd25;
    assign gq_prod = 59'(m_reg) * 59'(GM);

    assign y_full  = 37'(xs_reg) * 37'(LOG2E_Q16);
    assign lut_idx = {1'b0, y_reg[15:12]};
    assign lut_a   = pow2_frac(lut_idx);
    assign lut_b   = pow2_frac(lut_idx + 5'd1);
    assign v       = a_reg - 17'(prod_reg >> 12);

    assign g255 = 25'(g_reg) * 25'd255;
    assign g250 = 25'(g_reg) * 25'd250;
    assign bri  = (g250 > 25'd65536) ? g255[23:16] : 8'd0;

    assign last_pix = 7'(pix_reg) == (len_reg - 7'd1);
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    always_comb begin
        div_start = 1'b0;
        div_num   = NB'(nd) << 16;
        div_den   = tail_reg;
        case (state_reg)
            B_PIX: begin
                div_start = draw_reg && (d <= 0);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready && (state_reg != B_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        {len_reg, draw_reg, tail_reg, pos_reg} <= q_data;
                        pix_reg   <= '0;
                        state_reg <= B_PIX;
                    end
                end
                B_PIX: begin
                    if (!draw_reg) begin
                        g_reg     <= '0;
                        state_reg <= B_OUT;
                    end else if (d <= 0) begin
                        state_reg <= B_DIV;
                    end else begin
                        sq_reg    <= 40'(d16s) * 40'(d16s);
                        state_reg <= B_SQ;
                    end
                end
                B_SQ: begin
                    m_reg     <= 29'(sq25 >> 16);
                    state_reg <= B_GQ;
                end
                B_GQ: begin
                    xs_reg    <= (gq_prod[58:57] != '0) ? 20'hFFFFF : gq_prod[56:37];
                    state_reg <= B_Y;
                end
                B_DIV: begin
                    if (div_done) begin
                        xs_reg    <= (div_quot[NB-1:20] != '0) ? 20'hFFFFF : div_quot[19:0];
                        state_reg <= B_Y;
                    end
                end
                B_Y: begin
                    y_reg     <= y_full[36:16];
                    state_reg <= B_LUT;
                end
                B_LUT: begin
                    if (y_reg[20:16] >= 5'd16) begin
                        g_reg     <= '0;
                        state_reg <= B_OUT;
                    end else begin
                        a_reg     <= lut_a;
                        prod_reg  <= 27'(lut_a - lut_b) * 27'(y_reg[11:0]);
                        k_reg     <= y_reg[19:16];
                        state_reg <= B_G;
                    end
                end
                B_G: begin
                    g_reg     <= v >> k_reg;
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_pix_reg   <= pix_reg;
                        out_bri_reg   <= bri;
                        out_last_reg  <= last_pix;
                        if (last_pix) begin
                            state_reg <= B_IDLE;
                        end else begin
                            pix_reg   <= pix_reg + 6'd1;
                            state_reg <= B_PIX;
                        end
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_bri_reg, out_pix_reg};
    assign m_tlast  = out_last_reg;

endmodule

### src/led_swell_sweep_generator_unit.sv
// Swell sweep generator.
// Slave stream: one transfer per frame tick. s_tdata carries the frame number,
// s_tuser the restart flag. Master stream: one transfer per pixel of the strip,
// pixel index and brightness in m_tdata, m_tlast on the final pixel.
// Strip length and glide speed are set through the write port (cfg_we,
// cfg_index, cfg_wdata); write them only while no frame is in flight (not enforced).
// The front end works out a frame's tail and step by reciprocal multiply,
// queues it and advances the position, then, when a pause starts, draws a
// new pause count; s_tready is high only while the front end is idle.
// The back end renders pixels one at a time: a pixel on or behind the centre
// goes through a bit-serial divide of FRAC+24 steps, one ahead of it through
// a squared-distance multiply, and a paused frame's pixels go dark directly.
// A two-entry frame queue lets the front end take the next tick while the
// back end is still rendering. The output register holds a pixel while
// m_tready is low; the back end, then the queue, then s_tready stall behind it.
// Synchronous active-low reset restores the default registers, a gliding
// swell at its start position and a zero generator state; queue and output
// register empty.
module led_swell_sweep_generator_unit
    import lssg_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF,
    parameter int FRAC       = POS_FRAC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] frame_number
    input  logic        s_tuser,   // [0] restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] pixel_index, [13:6] brightness, [15:14] zero
    output logic        m_tlast
);

    localparam int DESC_W = 2 * FRAC + 21;

    logic              q_push;
    logic [DESC_W-1:0] q_in;
    logic              q_full;
    logic              q_pop;
    logic [DESC_W-1:0] q_out;
    logic              q_empty;

    lssg_front #(.MAX_PIXELS(MAX_PIXELS), .FRAC(FRAC), .DESC_W(DESC_W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_push    (q_push),
        .q_data    (q_in),
        .q_full    (q_full)
    );

    lssg_fifo #(.W(DESC_W)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    lssg_back #(.FRAC(FRAC), .DESC_W(DESC_W)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/sv/led_swell_sweep_generator_unit_tb.sv
module led_swell_sweep_generator_unit_tb;
    import lssg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [5:0] pixel_index;
        logic [7:0] brightness;
        logic       last_pixel;
    } pixel_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int mismatches = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    bit hold_off = 1'b0;

    led_swell_sweep_generator_unit i_dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    class swell_scoreboard;
        logic [6:0]  strip_len_reg = STRIP_LENGTH_RST;
        logic [7:0]  speed_reg = GLIDE_SPEED_RST;
        longint      position;
        logic [31:0] lcg_state = '0;
        int unsigned pause_left = 0;
        bit          paused = 1'b0;
        pixel_t      pending_pixels[$];

        function new();
            position = -(tail_of(64) + 2 * 65536);
        endfunction

        function int unsigned active_len();
            if (strip_len_reg < 1) return 1;
            if (strip_len_reg > 64) return 64;
            return strip_len_reg;
        endfunction

        function longint tail_of(input int unsigned len);
            return (longint'(len) * 4 * 65536) / 25 + 65536;
        endfunction

        function longint unsigned exp_neg(input longint unsigned x);
            longint unsigned y, f, k, frac, a, b, v;
            int unsigned idx;
            if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
            y = (x * 94548) >> 16;
            k = y >> 16;
            if (k >= 16) return 0;
            f = y & 16'hFFFF;
            idx = int'(f >> 12);
            frac = f & 12'hFFF;
            a = pow2_table(idx);
            b = pow2_table(idx + 1);
            v = a - (((a - b) * frac) >> 12);
            return v >> k;
        endfunction

        function longint unsigned pow2_table(input int unsigned j);
            longint unsigned t[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
            return t[j];
        endfunction

        function logic [7:0] swell_level(input int unsigned i, input longint tail);
            longint d;
            longint unsigned x, g;
            d = (longint'(i) << 16) - position;
            if (d <= 0) x = (longint'(-d) << 16) / tail;
            else x = (longint'(d) * longint'(d) * 25) / (162 * 65536);
            g = exp_neg(x);
            if (g * 250 > 65536) return 8'((g * 255) >> 16);
            return 8'd0;
        endfunction

        function void write_reg(input logic idx, input logic [7:0] val);
            if (idx == REG_STRIP_LENGTH) strip_len_reg = val[6:0];
            else speed_reg = val;
        endfunction

        function void note_frame(input logic restart, input logic [31:0] frame);
            int unsigned len;
            longint tail, step_q, end_q;
            pixel_t p;
            bit draw;
            len = active_len();
            tail = tail_of(len);
            if (restart) begin
                position = -(tail + 2 * 65536);
                lcg_state = frame * SEED_MUL + SEED_ADD;
                pause_left = 0;
                paused = 1'b0;
            end
            draw = !paused;
            for (int unsigned i = 0; i < len; i++) begin
                p.pixel_index = 6'(i);
                p.brightness = draw ? swell_level(i, tail) : 8'd0;
                p.last_pixel = (i == len - 1);
                pending_pixels.push_back(p);
            end
            if (draw) begin
                step_q = 65536 / 125 + (longint'(speed_reg) * 65536) / 1275;
                end_q = longint'(len) * 65536 + (19 * 65536) / 5;
                position += step_q;
                if (position > end_q) begin
                    paused = 1'b1;
                    lcg_state = lcg_state * LCG_MUL + LCG_ADD;
                    pause_left = 40 + (lcg_state % 180);
                end
            end else if (pause_left == 0) begin
                paused = 1'b0;
                position = -(tail + 2 * 65536);
            end else begin
                pause_left--;
            end
        endfunction

        task check_pixel(input logic [15:0] data, input logic last);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected transfer, pixel", int'(data[5:0]), -1);
                return;
            end
            want = pending_pixels.pop_front();
            if (data[5:0] !== want.pixel_index)
                report_mismatch("pixel_index", int'(data[5:0]), int'(want.pixel_index));
            if (data[13:6] !== want.brightness)
                report_mismatch("brightness", int'(data[13:6]), int'(want.brightness));
            if (data[15:14] !== 2'b00)
                report_mismatch("padding", int'(data[15:14]), 0);
            if (last !== want.last_pixel)
                report_mismatch("last_pixel", int'(last), int'(want.last_pixel));
        endtask
    endclass

    swell_scoreboard frame_board = new();

    // master side: check every pixel transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) frame_board.check_pixel(m_tdata, m_tlast);
    end

    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // tvalid stays high after a transfer; drain() drops it, the next call only while it idles
    task automatic send_frame(input logic restart, input logic [31:0] frame);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= restart;
        s_tdata <= frame;
        do @(posedge aclk); while (!s_tready);
        frame_board.note_frame(restart, frame);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_board.pending_pixels.size() != 0) @(posedge aclk);
        // let a trailing dark pass or queued work settle
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        frame_board.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_frames(input int n);
        for (int k = 0; k < n; k++)
            send_frame(($urandom_range(39) == 0), $urandom());
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, extremes of length and speed, restart corner seeds
        send_frame(1'b0, 32'h0);
        send_frame(1'b1, 32'hFFFF_FFFF);
        send_frame(1'b1, 32'h0);
        drain();
        write_cfg(REG_STRIP_LENGTH, 8'd0);
        write_cfg(REG_GLIDE_SPEED, 8'd255);
        repeat (6) send_frame(1'b0, 32'h5555_5555);
        drain();
        write_cfg(REG_STRIP_LENGTH, 8'd127);
        write_cfg(REG_GLIDE_SPEED, 8'd1);
        send_frame(1'b1, 32'hAAAA_AAAA);
        send_frame(1'b0, 32'h1234_5678);
        drain();
        write_cfg(REG_STRIP_LENGTH, 8'd2);
        write_cfg(REG_GLIDE_SPEED, 8'd255);
        // glide the swell along a short strip at top speed
        repeat (12) send_frame(1'b0, $urandom());
        drain();

        // short strips and high speed reach the pause often
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 33 : 60) : 0;
            snk_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 33 : 60) : 0;
            write_cfg(REG_STRIP_LENGTH, 8'($urandom_range(1, 8)));
            write_cfg(REG_GLIDE_SPEED, 8'($urandom_range(128, 255)));
            random_frames(60);
            drain();
        end

        // receiver holds off while frames keep coming
        src_idle_pct = 0;
        snk_stall_pct = 0;
        write_cfg(REG_STRIP_LENGTH, 8'd64);
        write_cfg(REG_GLIDE_SPEED, 8'($urandom_range(255)));
        fork
            begin
                hold_off = 1'b1;
                repeat (4000) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_frames(6);
        join
        drain();

        write_cfg(REG_STRIP_LENGTH, 8'($urandom_range(1, 20)));
        write_cfg(REG_GLIDE_SPEED, 8'($urandom_range(1, 255)));
        snk_stall_pct = 20;
        random_frames(40);
        drain();

        if (mismatches == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
